[hw/rtl/smf_pkg.sv]
`timescale 1ns / 1ps
package smf_pkg;
  localparam int unsigned MaxWidthDef = 31;
  localparam logic [4:0] WidthReset = 5'd3;
  localparam int unsigned MinWidth = 3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_OUTER,
    ST_INNER,
    ST_EMIT
  } smf_state_e;

  typedef struct packed {
    logic load;
    logic setup;
    logic start_out;
    logic start_cand;
    logic step_inner;
    logic next_cand;
    logic emit;
    logic next_out;
  } smf_cmd_t;

  typedef struct packed {
    logic out_valid;
    logic inner_done;
    logic found;
    logic outs_done;
  } smf_sts_t;
endpackage

[hw/rtl/smf_ctrl.sv]
`timescale 1ns / 1ps
module smf_ctrl
  import smf_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  logic     out_busy_i,
  input  smf_sts_t sts_i,
  output smf_cmd_t cmd_o
);
  smf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        cmd_o.setup = 1'b1;
        state_d = ST_OUTER;
      end
      ST_OUTER: begin
        if (sts_i.outs_done) begin
          state_d = ST_IDLE;
        end else if (!sts_i.out_valid) begin
          cmd_o.next_out = 1'b1;
        end else begin
          cmd_o.start_cand = 1'b1;
          state_d = ST_INNER;
        end
      end
      ST_INNER: begin
        if (!sts_i.inner_done) begin
          cmd_o.step_inner = 1'b1;
        end else if (sts_i.found) begin
          state_d = ST_EMIT;
        end else begin
          cmd_o.next_cand = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_busy_i) begin
          cmd_o.emit = 1'b1;
          cmd_o.next_out = 1'b1;
          state_d = ST_OUTER;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end
endmodule

[hw/rtl/smf_datapath.sv]
`timescale 1ns / 1ps
module smf_datapath
  import smf_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [4:0] width_q_i,
  input  logic [7:0] sample_i,
  input  logic       is_last_i,
  input  smf_cmd_t   cmd_i,
  output smf_sts_t   sts_o,
  output logic [7:0] res_value_o,
  output logic       res_last_o
);
  localparam int CW = ($clog2(MaxWidth + 1) > 5) ? $clog2(MaxWidth + 1) : 5;
  localparam int AW = $clog2(MaxWidth);

  logic [7:0] hist_q [MaxWidth];
  logic [CW-1:0] wid, hh, ll;
  logic [CW-1:0] count_q, seen_q, m_q, lo_q, n_q, r_q, a_q, b_q;
  logic [CW-1:0] less_q, leq_q, cclamp;
  logic [7:0] v_q, hb;
  logic last_q;
  logic cur_ok;
  logic [CW-1:0] mc;

  always_comb begin
    wid = CW'(width_q_i);
    if (wid < CW'(MinWidth)) wid = CW'(MinWidth);
    if (wid > CW'(MaxWidth)) wid = CW'(MaxWidth);
    hh = wid >> 1;
    ll = wid - CW'(1) - hh;
    cclamp = (seen_q > wid) ? wid : seen_q;
  end

  assign hb = hist_q[b_q[AW-1:0]];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int d = MaxWidth - 1; d > 0; d--) begin
        if (CW'(d) < wid) hist_q[d] <= hist_q[d-1];
      end
      hist_q[0] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= '0;
      last_q <= 1'b0;
      count_q <= '0;
      m_q <= '0;
      lo_q <= '0;
    end else begin
      if (cmd_i.load) begin
        last_q <= is_last_i;
        count_q <= (cclamp < wid) ? cclamp + CW'(1) : cclamp;
      end
      if (cmd_i.setup) begin
        m_q <= ll + CW'(1);
        lo_q <= last_q ? '0 : ll;
        seen_q <= last_q ? '0 : count_q;
      end else if (cmd_i.next_out) begin
        m_q <= m_q - CW'(1);
      end
    end
  end

  assign mc = m_q - CW'(1);
  assign cur_ok = mc < count_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.start_cand) begin
      n_q <= ((mc + hh + CW'(1)) > count_q) ? count_q : mc + hh + CW'(1);
      r_q <= (((mc + hh + CW'(1)) > count_q) ? count_q : mc + hh + CW'(1)) >> 1;
      a_q <= '0;
      v_q <= hist_q[0];
      b_q <= '0;
      less_q <= '0;
      leq_q <= '0;
    end else if (cmd_i.next_cand) begin
      a_q <= a_q + CW'(1);
      v_q <= hist_q[AW'(a_q + CW'(1))];
      b_q <= '0;
      less_q <= '0;
      leq_q <= '0;
    end else if (cmd_i.step_inner) begin
      b_q <= b_q + CW'(1);
      if (hb < v_q) less_q <= less_q + CW'(1);
      if (hb <= v_q) leq_q <= leq_q + CW'(1);
    end
  end

  assign sts_o.outs_done = (m_q == lo_q);
  assign sts_o.out_valid = cur_ok;
  assign sts_o.inner_done = (b_q == n_q);
  assign sts_o.found = (less_q <= r_q) && (r_q < leq_q);
  assign res_value_o = v_q;
  assign res_last_o = last_q && (mc == '0);
endmodule

[hw/rtl/sliding_median_filter_byte.sv]
`timescale 1ns / 1ps
// channel  | valid   | stall   | payload
// input    | valid_i | stall_o | sample_i, is_last_i
// output   | valid_o | stall_i | median_value_o, ends_sequence_o
// Each sample passes through load and setup, then the outer loop skips each
// position without enough history; each released median runs a rank search
// over the history registers (n window taps in range) and is then emitted.
// Reset clears control; history is written before any read.
// Output stall holds the result register and the controller waits on it before the next emit.
module sliding_median_filter_byte
  import smf_pkg::*;
#(
  parameter int unsigned MaxWidth = MaxWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       valid_i,
  output logic       stall_o,
  input  logic [7:0] sample_i,
  input  logic       is_last_i,
  output logic       valid_o,
  input  logic       stall_i,
  output logic [7:0] median_value_o,
  output logic       ends_sequence_o
);
  logic [4:0] width_q;
  smf_cmd_t cmd;
  smf_sts_t sts;
  logic [7:0] rv;
  logic rl, busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= WidthReset;
    end else if (cfg_we_i) begin
      width_q <= cfg_wdata_i;
    end
  end

  assign busy = valid_o && stall_i;

  smf_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i(valid_i), .in_stall_o(stall_o),
    .out_busy_i(busy), .sts_i(sts), .cmd_o(cmd)
  );

  smf_datapath #(.MaxWidth(MaxWidth)) u_dp (
    .clk_i, .rst_ni, .width_q_i(width_q), .sample_i, .is_last_i,
    .cmd_i(cmd), .sts_o(sts), .res_value_o(rv), .res_last_o(rl)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (cmd.emit) begin
      valid_o <= 1'b1;
    end else if (!stall_i) begin
      valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd.emit) begin
      median_value_o <= rv;
      ends_sequence_o <= rl;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && stall_i |=> valid_o && $stable(median_value_o))
    else $error("result dropped under stall");
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> !busy)
    else $error("emit while output busy");
  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |-> !stall_o)
    else $error("load while stalled");
endmodule

[tb/smf_checker.sv]
`timescale 1ns / 1ps
module smf_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [4:0] cfg_wdata_i,
  input  logic       valid_i,
  input  logic       stall_o,
  input  logic [7:0] sample_i,
  input  logic       is_last_i,
  input  logic       valid_o,
  input  logic       stall_i,
  input  logic [7:0] median_value_o,
  input  logic       ends_sequence_o,
  output int         pending_o,
  output int         fail_count_o
);
  import smf_pkg::*;

  typedef struct packed {
    logic [7:0] med;
    logic       fin;
  } median_word_t;

  median_word_t median_q[$];
  logic [7:0]   taps[MaxWidthDef];
  logic [4:0]   width_reg;
  int unsigned  seen;

  assign pending_o = median_q.size();

  function automatic logic [7:0] window_median(int unsigned n);
    logic [7:0] srt[MaxWidthDef];
    logic [7:0] t;
    for (int i = 0; i < n; i++) srt[i] = taps[i];
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j + 1 < n - i; j++) begin
        if (srt[j] > srt[j+1]) begin
          t = srt[j];
          srt[j] = srt[j+1];
          srt[j+1] = t;
        end
      end
    end
    return srt[n/2];
  endfunction

  task automatic predict_medians(logic [7:0] s, logic last);
    int unsigned w, h, tail, cnt, n;
    int lo;
    median_word_t e;
    w = width_reg;
    if (w < MinWidth) w = MinWidth;
    if (w > MaxWidthDef) w = MaxWidthDef;
    h = w / 2;
    tail = w - 1 - h;
    cnt = seen;
    if (cnt > w) cnt = w;
    for (int d = w - 1; d > 0; d--) taps[d] = taps[d-1];
    taps[0] = s;
    if (cnt < w) cnt++;
    lo = last ? 0 : tail;
    for (int m = tail; m >= lo; m--) begin
      if (m < cnt) begin
        n = m + h + 1;
        if (n > cnt) n = cnt;
        e.med = window_median(n);
        e.fin = last && (m == 0);
        median_q.push_back(e);
      end
    end
    seen = last ? 0 : cnt;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    median_word_t e;
    if (!rst_ni) begin
      width_reg = WidthReset;
      seen = 0;
      median_q.delete();
      fail_count_o = 0;
      for (int i = 0; i < MaxWidthDef; i++) taps[i] = '0;
    end else begin
      if (cfg_we_i) width_reg = cfg_wdata_i;
      if (valid_i && !stall_o) predict_medians(sample_i, is_last_i);
      if (valid_o && !stall_i) begin
        if (median_q.size() == 0) begin
          $display("%0t: unexpected word med=%0d fin=%0b", $time, median_value_o,
                   ends_sequence_o);
          fail_count_o++;
        end else begin
          e = median_q.pop_front();
          if (e.med !== median_value_o) begin
            $display("%0t: median expected %0d actual %0d", $time, e.med, median_value_o);
            fail_count_o++;
          end
          if (e.fin !== ends_sequence_o) begin
            $display("%0t: ends_sequence expected %0b actual %0b", $time, e.fin,
                     ends_sequence_o);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

[tb/sliding_median_filter_byte_tb.sv]
`timescale 1ns / 1ps
module sliding_median_filter_byte_tb;
  localparam int QuietCycles = 17000;
  localparam int CycleLimit  = 3000000;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic       valid_i = 1'b0;
  logic       stall_o;
  logic [7:0] sample_i = '0;
  logic       is_last_i = 1'b0;
  logic       valid_o;
  logic       stall_i = 1'b0;
  logic [7:0] median_value_o;
  logic       ends_sequence_o;
  int         pending;
  int         fail_count;
  int         tx_gap_max = 18;
  int         rx_gap_max = 18;
  bit         rx_hold_req = 1'b0;
  int         cycles = 0;

  always #6 clk_i = ~clk_i;

  sliding_median_filter_byte dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .valid_i, .stall_o, .sample_i, .is_last_i,
    .valid_o, .stall_i, .median_value_o, .ends_sequence_o
  );

  smf_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .valid_i, .stall_o, .sample_i, .is_last_i,
    .valid_o, .stall_i, .median_value_o, .ends_sequence_o,
    .pending_o(pending), .fail_count_o(fail_count)
  );

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall per word, plus one long hold-off on request
  initial begin
    int k;
    @(posedge rst_ni);
    forever begin
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        k = 4000;
      end else begin
        k = $urandom_range(0, rx_gap_max);
      end
      if (k > 0) begin
        stall_i <= 1'b1;
        repeat (k) @(posedge clk_i);
      end
      stall_i <= 1'b0;
      do @(posedge clk_i); while (!(valid_o && !stall_i));
    end
  end

  task automatic push_sample(logic [7:0] s, logic last);
    int k;
    k = $urandom_range(0, tx_gap_max);
    if (k > 0) begin
      valid_i <= 1'b0;
      repeat (k) @(posedge clk_i);
    end
    valid_i   <= 1'b1;
    sample_i  <= s;
    is_last_i <= last;
    do @(posedge clk_i); while (!(valid_i && !stall_o));
  endtask

  task automatic drain();
    valid_i <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (QuietCycles) @(posedge clk_i);
  endtask

  task automatic set_width(logic [4:0] v);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic random_sequence(int len);
    for (int i = 0; i < len; i++) begin
      push_sample(8'($urandom_range(0, 255)), i == len - 1);
    end
  endtask

  initial begin
    int len, sent;
    logic [4:0] w;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // width below three, single-sample sequence
    set_width(5'd0);
    push_sample(8'd255, 1'b1);
    push_sample(8'd0, 1'b0);
    push_sample(8'd255, 1'b0);
    push_sample(8'd0, 1'b0);
    push_sample(8'd128, 1'b1);
    drain();
    // widest window, sequence shorter than the window
    set_width(5'd31);
    for (int i = 0; i < 8; i++) push_sample((i % 2) ? 8'd255 : 8'd0, i == 7);
    drain();
    // even width gives upper median
    set_width(5'd4);
    push_sample(8'd10, 1'b0);
    push_sample(8'd200, 1'b0);
    push_sample(8'd30, 1'b0);
    push_sample(8'd90, 1'b1);
    drain();
    // width change inside a sequence
    set_width(5'd7);
    push_sample(8'd1, 1'b0);
    push_sample(8'd254, 1'b0);
    push_sample(8'd127, 1'b0);
    drain();
    set_width(5'd2);
    push_sample(8'd64, 1'b0);
    push_sample(8'd3, 1'b1);
    drain();

    // pressure: long receiver hold while the sender streams
    set_width(5'd9);
    tx_gap_max = 0;
    rx_hold_req = 1'b1;
    random_sequence(14);
    drain();
    tx_gap_max = 18;

    sent = 0;
    while (sent < 84) begin
      case ($urandom_range(0, 9))
        0: w = 5'd31;
        1: w = 5'($urandom_range(0, 31));
        default: w = 5'($urandom_range(0, 9));
      endcase
      set_width(w);
      if ($urandom_range(0, 3) == 0) begin
        tx_gap_max = 0;
        rx_gap_max = 0;
      end else begin
        tx_gap_max = 18;
        rx_gap_max = 18;
      end
      len = (w > 9) ? $urandom_range(1, 8) : $urandom_range(1, 14);
      random_sequence(len);
      sent += len;
      drain();
    end

    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
